// File: rtl/accented_glyph_composer_defines.svh
// ----------------------------------------------------------------------------
// accented_glyph_composer_defines
// Assertion macros for the accented glyph composer.
// ----------------------------------------------------------------------------
`ifndef ACCENTED_GLYPH_COMPOSER_DEFINES_SVH
`define ACCENTED_GLYPH_COMPOSER_DEFINES_SVH
`ifndef SYNTH
`define AGC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define AGC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define AGC_ASSERT_IMPL(name, ante, cons)
`define AGC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: rtl/agc_pkg.sv
// ----------------------------------------------------------------------------
// agc_pkg
// Types, mark codes, glyph table and constant-divisor helpers.
// ----------------------------------------------------------------------------
package agc_pkg;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CAP,
    KIND_SML
  } kind_t;

  typedef enum logic [2:0] {
    CLS_GENERAL,
    CLS_COMMA_BELOW,
    CLS_COMMA_UR,
    CLS_COMMA_URI,
    CLS_STROKE
  } cls_t;

  localparam logic [9:0] MARK_ACUTE     = 10'h0b4;
  localparam logic [9:0] MARK_CEDILLA   = 10'h0b8;
  localparam logic [9:0] MARK_MACRON    = 10'd175;
  localparam logic [9:0] MARK_CIRC      = 10'h2c6;
  localparam logic [9:0] MARK_TILDE     = 10'h2dc;
  localparam logic [9:0] MARK_DOT       = 10'h2d9;
  localparam logic [9:0] MARK_OGONEK    = 10'h2db;
  localparam logic [9:0] MARK_STROKE    = 10'h02d;
  localparam logic [9:0] MARK_BREVE     = 10'h2d8;
  localparam logic [9:0] MARK_CARON     = 10'h2c7;
  localparam logic [9:0] MARK_MIDDOT    = 10'h0b7;
  localparam logic [9:0] MARK_DACUTE    = 10'h2dd;
  localparam logic [9:0] MARK_DIAER     = 10'h0a8;
  localparam logic [9:0] MARK_RING      = 10'h2da;
  localparam logic [9:0] MARK_COMMA_T   = 10'h02c;
  localparam logic [9:0] MARK_COMMA_UR  = 10'h001;
  localparam logic [9:0] MARK_COMMA_URI = 10'h002;

  localparam logic [15:0] RECIP_3  = 16'd21846;
  localparam logic [15:0] RECIP_5  = 16'd13108;
  localparam logic [15:0] RECIP_10 = 16'd6554;
  localparam logic [15:0] RECIP_19 = 16'd3450;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] letter;
    logic [9:0] mark;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] letter;
    logic [9:0] mark;
    cls_t       cls;
    logic       shrink;
    logic       ring;
  } dec_t;

  function automatic logic [13:0] div_recip(input logic [13:0] n, input logic [15:0] m);
    logic [29:0] p;
    p = {16'b0, n} * {14'b0, m};
    return p[29:16];
  endfunction

  function automatic entry_t ent(input kind_t k, input logic [6:0] up, input logic [9:0] m);
    entry_t e;
    e.kind   = k;
    e.letter = (k == KIND_SML) ? (up | 7'h20) : up;
    e.mark   = m;
    return e;
  endfunction

  function automatic entry_t glyph_entry(input logic [6:0] idx);
    entry_t e;
    case (idx)
      7'd0:   e = ent(KIND_CAP, 7'h41, MARK_MACRON);
      7'd1:   e = ent(KIND_SML, 7'h41, MARK_MACRON);
      7'd2:   e = ent(KIND_CAP, 7'h41, MARK_BREVE);
      7'd3:   e = ent(KIND_SML, 7'h41, MARK_BREVE);
      7'd4:   e = ent(KIND_CAP, 7'h41, MARK_OGONEK);
      7'd5:   e = ent(KIND_SML, 7'h41, MARK_OGONEK);
      7'd6:   e = ent(KIND_CAP, 7'h43, MARK_ACUTE);
      7'd7:   e = ent(KIND_SML, 7'h43, MARK_ACUTE);
      7'd8:   e = ent(KIND_CAP, 7'h43, MARK_CIRC);
      7'd9:   e = ent(KIND_SML, 7'h43, MARK_CIRC);
      7'd10:  e = ent(KIND_CAP, 7'h43, MARK_DOT);
      7'd11:  e = ent(KIND_SML, 7'h43, MARK_DOT);
      7'd12:  e = ent(KIND_CAP, 7'h43, MARK_CARON);
      7'd13:  e = ent(KIND_SML, 7'h43, MARK_CARON);
      7'd14:  e = ent(KIND_CAP, 7'h44, MARK_CARON);
      7'd15:  e = ent(KIND_SML, 7'h44, MARK_COMMA_UR);
      7'd16:  e = ent(KIND_CAP, 7'h44, MARK_STROKE);
      7'd17:  e = ent(KIND_SML, 7'h44, MARK_STROKE);
      7'd18:  e = ent(KIND_CAP, 7'h45, MARK_MACRON);
      7'd19:  e = ent(KIND_SML, 7'h45, MARK_MACRON);
      7'd20:  e = ent(KIND_CAP, 7'h45, MARK_BREVE);
      7'd21:  e = ent(KIND_SML, 7'h45, MARK_BREVE);
      7'd22:  e = ent(KIND_CAP, 7'h45, MARK_DOT);
      7'd23:  e = ent(KIND_SML, 7'h45, MARK_DOT);
      7'd24:  e = ent(KIND_CAP, 7'h45, MARK_OGONEK);
      7'd25:  e = ent(KIND_SML, 7'h45, MARK_OGONEK);
      7'd26:  e = ent(KIND_CAP, 7'h45, MARK_CARON);
      7'd27:  e = ent(KIND_SML, 7'h45, MARK_CARON);
      7'd28:  e = ent(KIND_CAP, 7'h47, MARK_CIRC);
      7'd29:  e = ent(KIND_SML, 7'h47, MARK_CIRC);
      7'd30:  e = ent(KIND_CAP, 7'h47, MARK_BREVE);
      7'd31:  e = ent(KIND_SML, 7'h47, MARK_BREVE);
      7'd32:  e = ent(KIND_CAP, 7'h47, MARK_DOT);
      7'd33:  e = ent(KIND_SML, 7'h47, MARK_DOT);
      7'd34:  e = ent(KIND_CAP, 7'h47, MARK_CEDILLA);
      7'd35:  e = ent(KIND_SML, 7'h47, MARK_CEDILLA);
      7'd36:  e = ent(KIND_CAP, 7'h48, MARK_CIRC);
      7'd37:  e = ent(KIND_SML, 7'h48, MARK_CIRC);
      7'd38:  e = ent(KIND_CAP, 7'h48, MARK_STROKE);
      7'd39:  e = ent(KIND_SML, 7'h48, MARK_STROKE);
      7'd40:  e = ent(KIND_CAP, 7'h49, MARK_TILDE);
      7'd41:  e = ent(KIND_SML, 7'h49, MARK_TILDE);
      7'd42:  e = ent(KIND_CAP, 7'h49, MARK_MACRON);
      7'd43:  e = ent(KIND_SML, 7'h49, MARK_MACRON);
      7'd44:  e = ent(KIND_CAP, 7'h49, MARK_BREVE);
      7'd45:  e = ent(KIND_SML, 7'h49, MARK_BREVE);
      7'd46:  e = ent(KIND_CAP, 7'h49, MARK_OGONEK);
      7'd47:  e = ent(KIND_SML, 7'h49, MARK_OGONEK);
      7'd48:  e = ent(KIND_CAP, 7'h49, MARK_DOT);
      7'd52:  e = ent(KIND_CAP, 7'h4a, MARK_CIRC);
      7'd53:  e = ent(KIND_SML, 7'h4a, MARK_CIRC);
      7'd54:  e = ent(KIND_CAP, 7'h4b, MARK_CEDILLA);
      7'd55:  e = ent(KIND_SML, 7'h4b, MARK_CEDILLA);
      7'd57:  e = ent(KIND_CAP, 7'h4c, MARK_ACUTE);
      7'd58:  e = ent(KIND_SML, 7'h4c, MARK_ACUTE);
      7'd59:  e = ent(KIND_CAP, 7'h4c, MARK_CEDILLA);
      7'd60:  e = ent(KIND_SML, 7'h4c, MARK_CEDILLA);
      7'd61:  e = ent(KIND_CAP, 7'h4c, MARK_COMMA_URI);
      7'd62:  e = ent(KIND_SML, 7'h4c, MARK_COMMA_UR);
      7'd63:  e = ent(KIND_CAP, 7'h4c, MARK_MIDDOT);
      7'd64:  e = ent(KIND_SML, 7'h4c, MARK_MIDDOT);
      7'd65:  e = ent(KIND_CAP, 7'h4c, MARK_STROKE);
      7'd66:  e = ent(KIND_SML, 7'h4c, MARK_STROKE);
      7'd67:  e = ent(KIND_CAP, 7'h4e, MARK_ACUTE);
      7'd68:  e = ent(KIND_SML, 7'h4e, MARK_ACUTE);
      7'd69:  e = ent(KIND_CAP, 7'h4e, MARK_CEDILLA);
      7'd70:  e = ent(KIND_SML, 7'h4e, MARK_CEDILLA);
      7'd71:  e = ent(KIND_CAP, 7'h4e, MARK_CARON);
      7'd72:  e = ent(KIND_SML, 7'h4e, MARK_CARON);
      7'd76:  e = ent(KIND_CAP, 7'h4f, MARK_MACRON);
      7'd77:  e = ent(KIND_SML, 7'h4f, MARK_MACRON);
      7'd78:  e = ent(KIND_CAP, 7'h4f, MARK_BREVE);
      7'd79:  e = ent(KIND_SML, 7'h4f, MARK_BREVE);
      7'd80:  e = ent(KIND_CAP, 7'h4f, MARK_DACUTE);
      7'd81:  e = ent(KIND_SML, 7'h4f, MARK_DACUTE);
      7'd84:  e = ent(KIND_CAP, 7'h52, MARK_ACUTE);
      7'd85:  e = ent(KIND_SML, 7'h52, MARK_ACUTE);
      7'd86:  e = ent(KIND_CAP, 7'h52, MARK_CEDILLA);
      7'd87:  e = ent(KIND_SML, 7'h52, MARK_CEDILLA);
      7'd88:  e = ent(KIND_CAP, 7'h52, MARK_CARON);
      7'd89:  e = ent(KIND_SML, 7'h52, MARK_CARON);
      7'd90:  e = ent(KIND_CAP, 7'h53, MARK_ACUTE);
      7'd91:  e = ent(KIND_SML, 7'h53, MARK_ACUTE);
      7'd92:  e = ent(KIND_CAP, 7'h53, MARK_CIRC);
      7'd93:  e = ent(KIND_SML, 7'h53, MARK_CIRC);
      7'd94:  e = ent(KIND_CAP, 7'h53, MARK_CEDILLA);
      7'd95:  e = ent(KIND_SML, 7'h53, MARK_CEDILLA);
      7'd96:  e = ent(KIND_CAP, 7'h53, MARK_CARON);
      7'd97:  e = ent(KIND_SML, 7'h53, MARK_CARON);
      7'd98:  e = ent(KIND_CAP, 7'h54, MARK_CEDILLA);
      7'd99:  e = ent(KIND_SML, 7'h54, MARK_CEDILLA);
      7'd100: e = ent(KIND_CAP, 7'h54, MARK_CARON);
      7'd101: e = ent(KIND_SML, 7'h54, MARK_COMMA_T);
      7'd102: e = ent(KIND_CAP, 7'h54, MARK_STROKE);
      7'd103: e = ent(KIND_SML, 7'h54, MARK_STROKE);
      7'd104: e = ent(KIND_CAP, 7'h55, MARK_TILDE);
      7'd105: e = ent(KIND_SML, 7'h55, MARK_TILDE);
      7'd106: e = ent(KIND_CAP, 7'h55, MARK_MACRON);
      7'd107: e = ent(KIND_SML, 7'h55, MARK_MACRON);
      7'd108: e = ent(KIND_CAP, 7'h55, MARK_BREVE);
      7'd109: e = ent(KIND_SML, 7'h55, MARK_BREVE);
      7'd110: e = ent(KIND_CAP, 7'h55, MARK_RING);
      7'd111: e = ent(KIND_SML, 7'h55, MARK_RING);
      7'd112: e = ent(KIND_CAP, 7'h55, MARK_DACUTE);
      7'd113: e = ent(KIND_SML, 7'h55, MARK_DACUTE);
      7'd114: e = ent(KIND_CAP, 7'h55, MARK_OGONEK);
      7'd115: e = ent(KIND_SML, 7'h55, MARK_OGONEK);
      7'd116: e = ent(KIND_CAP, 7'h57, MARK_CIRC);
      7'd117: e = ent(KIND_SML, 7'h57, MARK_CIRC);
      7'd118: e = ent(KIND_CAP, 7'h59, MARK_CIRC);
      7'd119: e = ent(KIND_SML, 7'h59, MARK_CIRC);
      7'd120: e = ent(KIND_CAP, 7'h59, MARK_DIAER);
      7'd121: e = ent(KIND_CAP, 7'h5a, MARK_ACUTE);
      7'd122: e = ent(KIND_SML, 7'h5a, MARK_ACUTE);
      7'd123: e = ent(KIND_CAP, 7'h5a, MARK_DOT);
      7'd124: e = ent(KIND_SML, 7'h5a, MARK_DOT);
      7'd125: e = ent(KIND_CAP, 7'h5a, MARK_CARON);
      7'd126: e = ent(KIND_SML, 7'h5a, MARK_CARON);
      default: e = ent(KIND_NONE, 7'h00, 10'h000);
    endcase
    return e;
  endfunction

endpackage

// File: rtl/accented_glyph_composer.sv
// ----------------------------------------------------------------------------
// accented_glyph_composer: Latin Extended-A glyph composition from base + mark
// Stage s1 registers the inputs and the output stage registers the result.
// One character per cycle unless out_stall holds the output; lookup and divide-by-constant
// math sit in one combinational stage. Reset (rst, synchronous) empties both stages.
// ----------------------------------------------------------------------------
`include "accented_glyph_composer_defines.svh"

module accented_glyph_composer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [10:0]        code,
  input  logic [9:0]         base_width,
  input  logic               base_ok,
  input  logic [9:0]         mark_width,
  input  logic               mark_ok,
  input  logic [9:0]         small_mark_width,
  input  logic [9:0]         font_height,
  input  logic               italic,
  input  logic               fixed_pitch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               valid_res,
  output logic [6:0]         base_char,
  output logic [9:0]         mark_glyph,
  output logic [9:0]         mark_height,
  output logic signed [11:0] offset_x,
  output logic signed [11:0] offset_y
);
  import agc_pkg::*;

  logic               s1_valid;
  logic [10:0]        s1_code;
  logic [9:0]         s1_base_width;
  logic               s1_base_ok;
  logic [9:0]         s1_mark_width;
  logic               s1_mark_ok;
  logic [9:0]         s1_small_mark_width;
  logic [9:0]         s1_font_height;
  logic               s1_italic;
  logic               s1_fixed_pitch;

  logic               out_load;
  logic               in_xfer;
  dec_t               dec;
  logic [9:0]         mh_next;
  logic signed [11:0] ox_next;
  logic signed [11:0] oy_next;

  assign out_load = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_load;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_code             <= code;
      s1_base_width       <= base_width;
      s1_base_ok          <= base_ok;
      s1_mark_width       <= mark_width;
      s1_mark_ok          <= mark_ok;
      s1_small_mark_width <= small_mark_width;
      s1_font_height      <= font_height;
      s1_italic           <= italic;
      s1_fixed_pitch      <= fixed_pitch;
    end
  end

  agc_decode u_decode (
    .code        (s1_code),
    .base_ok     (s1_base_ok),
    .mark_ok     (s1_mark_ok),
    .fixed_pitch (s1_fixed_pitch),
    .dec         (dec)
  );

  agc_offset u_offset (
    .dec              (dec),
    .base_width       (s1_base_width),
    .mark_width       (s1_mark_width),
    .small_mark_width (s1_small_mark_width),
    .font_height      (s1_font_height),
    .italic           (s1_italic),
    .mark_height      (mh_next),
    .offset_x         (ox_next),
    .offset_y         (oy_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      valid_res   <= dec.ok;
      base_char   <= dec.letter;
      mark_glyph  <= dec.mark;
      mark_height <= mh_next;
      offset_x    <= ox_next;
      offset_y    <= oy_next;
    end
  end

  `AGC_ASSERT_NEXT(a_in_to_s1, in_valid && !in_stall, s1_valid)
  `AGC_ASSERT_NEXT(a_s1_to_out, s1_valid && out_load, out_valid)
  `AGC_ASSERT_IMPL(a_reject_zero, out_valid && !valid_res,
    base_char == 7'h00 && mark_glyph == 10'h000 && mark_height == 10'd0 &&
    offset_x == 12'sd0 && offset_y == 12'sd0)
  `AGC_ASSERT_IMPL(a_y_upward, out_valid, offset_y[11] || offset_y == 12'sd0)

endmodule

// File: rtl/agc_decode.sv
// ----------------------------------------------------------------------------
// agc_decode
// Range check, glyph table lookup and mark classification.
// ----------------------------------------------------------------------------
module agc_decode (
  input  logic [10:0]        code,
  input  logic               base_ok,
  input  logic               mark_ok,
  input  logic               fixed_pitch,
  output agc_pkg::dec_t      dec
);
  import agc_pkg::*;

  entry_t     e;
  logic       in_range;
  logic       ok;
  logic [9:0] mark;
  cls_t       cls;

  always_comb begin
    e        = glyph_entry(code[6:0]);
    in_range = (code[10:7] == 4'b0010);
    ok       = in_range && (e.kind != KIND_NONE) && base_ok && mark_ok;
    mark     = e.mark;
    // monospaced: comma above right falls back to caron
    if ((mark == MARK_COMMA_UR) && fixed_pitch) begin
      mark = MARK_CARON;
    end
    if (mark == MARK_COMMA_T) begin
      cls = CLS_COMMA_BELOW;
    end else if (mark == MARK_COMMA_UR) begin
      cls = CLS_COMMA_UR;
    end else if (mark == MARK_COMMA_URI) begin
      cls = CLS_COMMA_URI;
    end else if (mark == MARK_STROKE) begin
      cls = CLS_STROKE;
    end else begin
      cls = CLS_GENERAL;
    end

    dec.ok     = ok;
    dec.letter = ok ? e.letter : 7'h00;
    if (!ok) begin
      dec.mark = 10'h000;
    end else if ((cls == CLS_COMMA_UR) || (cls == CLS_COMMA_URI)) begin
      dec.mark = MARK_COMMA_T;
    end else begin
      dec.mark = mark;
    end
    dec.cls    = cls;
    dec.shrink = (cls == CLS_GENERAL) && (mark != MARK_OGONEK) &&
                 (mark != MARK_CEDILLA) && (e.kind == KIND_CAP);
    dec.ring   = (mark == MARK_RING);
  end

endmodule

// File: rtl/agc_offset.sv
// ----------------------------------------------------------------------------
// agc_offset
// Mark height and mark offset arithmetic with constant divisors.
// ----------------------------------------------------------------------------
module agc_offset (
  input  agc_pkg::dec_t      dec,
  input  logic [9:0]         base_width,
  input  logic [9:0]         mark_width,
  input  logic [9:0]         small_mark_width,
  input  logic [9:0]         font_height,
  input  logic               italic,
  output logic [9:0]         mark_height,
  output logic signed [11:0] offset_x,
  output logic signed [11:0] offset_y
);
  import agc_pkg::*;

  logic [9:0]  mw_sel;
  logic [11:0] h3;
  logic [13:0] h9;
  logic [9:0]  q_h34;
  logic [9:0]  q_h23;
  logic [9:0]  q_h910;
  logic [9:0]  q_h19;
  logic [9:0]  q_h10;
  logic [9:0]  q_cw25;
  logic [9:0]  q_mw5;
  logic [9:0]  q_mw3;
  logic [11:0] diff;
  logic [11:0] diff_adj;
  logic [11:0] half;
  logic [11:0] x;
  logic [11:0] y;
  logic [9:0]  mh;

  always_comb begin
    mw_sel   = dec.shrink ? small_mark_width : mark_width;
    h3       = {1'b0, font_height, 1'b0} + {2'b00, font_height};
    h9       = {1'b0, font_height, 3'b000} + {4'b0000, font_height};
    q_h34    = h3[11:2];
    q_h23    = 10'(div_recip({3'b000, font_height, 1'b0}, RECIP_3));
    q_h910   = 10'(div_recip(h9, RECIP_10));
    q_h19    = 10'(div_recip({4'b0000, font_height}, RECIP_19));
    q_h10    = 10'(div_recip({4'b0000, font_height}, RECIP_10));
    q_cw25   = 10'(div_recip({3'b000, base_width, 1'b0}, RECIP_5));
    q_mw5    = 10'(div_recip({4'b0000, mw_sel}, RECIP_5));
    q_mw3    = 10'(div_recip({4'b0000, mark_width}, RECIP_3));
    // signed halving toward zero
    diff     = {2'b00, base_width} - {2'b00, mw_sel};
    diff_adj = diff + {11'b0, diff[11]};
    half     = {diff_adj[11], diff_adj[11:1]};

    x  = 12'd0;
    y  = 12'd0;
    mh = font_height;
    case (dec.cls)
      CLS_COMMA_BELOW: begin
        y = 12'd0 - {2'b00, q_h34};
        x = {2'b00, q_cw25} + (italic ? {3'b000, mark_width[9:1]} : 12'd0);
      end
      CLS_COMMA_UR: begin
        y = 12'd0 - {2'b00, q_h23};
        x = {2'b00, base_width} - {4'b0000, mark_width[9:2]} +
            (italic ? {2'b00, q_mw3} : 12'd0);
      end
      CLS_COMMA_URI: begin
        y = 12'd0 - {2'b00, q_h23};
        x = {2'b00, base_width} - {3'b000, mark_width[9:1]} +
            (italic ? {2'b00, q_mw3} : 12'd0);
      end
      CLS_STROKE: begin
        x = 12'd0;
      end
      CLS_GENERAL: begin
        if (dec.shrink) begin
          mh = q_h910;
          y  = 12'd0 - {2'b00, (dec.ring ? q_h19 : q_h10)};
        end
        x = half + (italic ? {2'b00, q_mw5} : 12'd0);
      end
      default: begin
        x = 12'd0;
      end
    endcase

    mark_height = dec.ok ? mh : 10'd0;
    offset_x    = dec.ok ? $signed(x) : 12'sd0;
    offset_y    = dec.ok ? $signed(y) : 12'sd0;
  end

endmodule
